[rtl/core/bcat_pkg.sv]
// ----------------------------------------------------------------------------
// bcat_pkg
// Shared types and constants of the blockade confirmation and age table.
// ----------------------------------------------------------------------------
package bcat_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int EDGE_W  = 16;
	localparam int CNT_W   = 8;
	localparam int TIME_W  = 32;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;

	localparam logic [1:0] OP_OBSERVE = 2'd0;
	localparam logic [1:0] OP_FORCE   = 2'd1;
	localparam logic [1:0] OP_DELETE  = 2'd2;
	localparam logic [1:0] OP_SWEEP   = 2'd3;

	localparam logic [2:0] ACT_NONE     = 3'd0;
	localparam logic [2:0] ACT_BLOCK    = 3'd1;
	localparam logic [2:0] ACT_REMOVED  = 3'd2;
	localparam logic [2:0] ACT_FILTERED = 3'd3;
	localparam logic [2:0] ACT_FULL     = 3'd4;

	localparam logic REG_PUBLISH_MIN    = 1'b0;
	localparam logic REG_MAX_UNOBSERVED = 1'b1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_DRAIN,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic [EDGE_W-1:0] edge_id;
		logic [CNT_W-1:0]  count;
		logic [TIME_W-1:0] seen;
		logic              published;
	} entry_t;

	typedef struct packed {
		logic load;
		logic emit_filt;
		logic scan_start;
		logic scan_step;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic filt;
		logic idx_last;
	} ctl_sts_t;

endpackage

[rtl/core/bcat_ctrl.sv]
// ----------------------------------------------------------------------------
// bcat_ctrl
// Sequencer: decode a word; unless filtered, walk the table once, then commit.
// ----------------------------------------------------------------------------
module bcat_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output bcat_pkg::ctl_cmd_t  cmd,
	input  bcat_pkg::ctl_sts_t  sts
);
	import bcat_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = sts.filt ? S_IDLE : S_SCAN;
			end
			S_SCAN: begin
				if (sts.idx_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			S_DECIDE: begin
				cmd.emit_filt  = sts.filt;
				cmd.scan_start = !sts.filt;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			S_DRAIN: begin
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

[rtl/core/bcat_dp.sv]
// ----------------------------------------------------------------------------
// bcat_dp
// Datapath: item registers, entry memory, valid bits, scan pipeline,
// held result for sweeps and the result registers.
// ----------------------------------------------------------------------------
module bcat_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bcat_pkg::ctl_cmd_t             cmd,
	output bcat_pkg::ctl_sts_t             sts,
	input  logic [1:0]                     opcode,
	input  logic [bcat_pkg::EDGE_W-1:0]    edge_id,
	input  logic                           already_blocked,
	input  logic                           zone_edge,
	input  logic                           intersection_edge,
	input  logic [bcat_pkg::TIME_W-1:0]    now,
	input  logic [bcat_pkg::CNT_W-1:0]     publish_min,
	input  logic [bcat_pkg::TIME_W-1:0]    max_unobserved,
	output logic                           out_valid,
	output logic [bcat_pkg::EDGE_W-1:0]    out_edge,
	output logic [2:0]                     action,
	output logic [bcat_pkg::CNT_W-1:0]     obs_count,
	output logic                           last
);
	import bcat_pkg::*;

	logic [1:0]        op_q;
	logic [EDGE_W-1:0] edge_q;
	logic              blk_q, zone_q, inter_q;
	logic [TIME_W-1:0] now_q;

	entry_t            mem_q [ENTRIES];
	entry_t            rd_s1;
	logic              pend_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  idx_q;
	logic [ENTRIES-1:0] valid_q;

	logic              hit_q;
	logic [IDX_W-1:0]  hit_idx_q;
	logic [CNT_W-1:0]  hit_cnt_q;
	logic              hit_pub_q;

	logic              held_v_q;
	logic [EDGE_W-1:0] held_edge_q;
	logic [2:0]        held_act_q;
	logic [CNT_W-1:0]  held_cnt_q;

	logic              out_valid_q;
	logic [EDGE_W-1:0] out_edge_q;
	logic [2:0]        out_act_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_last_q;

	logic              scan_live;
	logic              match;
	logic [TIME_W-1:0] age;
	logic              stale;
	logic              sw_new;
	logic [2:0]        sw_act;
	logic [CNT_W-1:0]  sw_cnt;

	logic              free_any;
	logic [IDX_W-1:0]  free_idx;
	logic              slot_ok;
	logic [IDX_W-1:0]  slot_idx;
	logic [CNT_W-1:0]  old_cnt;
	logic              old_pub;
	logic [CNT_W-1:0]  new_cnt;
	logic              new_pub;
	logic [2:0]        upd_act;
	logic              wr_en;
	entry_t            wr_data;

	logic              emit;
	logic [EDGE_W-1:0] em_edge;
	logic [2:0]        em_act;
	logic [CNT_W-1:0]  em_cnt;
	logic              em_last;

	assign sts.filt = ((op_q == OP_OBSERVE) || (op_q == OP_FORCE)) &&
		(blk_q || zone_q || ((op_q == OP_OBSERVE) && inter_q));
	assign sts.idx_last = (idx_q == IDX_W'(ENTRIES - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			edge_q  <= edge_id;
			blk_q   <= already_blocked;
			zone_q  <= zone_edge;
			inter_q <= intersection_edge;
			now_q   <= now;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			rd_s1 <= mem_q[idx_q];
		end
		if (wr_en) begin
			mem_q[slot_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			idx_q   <= '0;
		end else begin
			pend_s1 <= cmd.scan_step;
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.scan_step) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	assign scan_live = pend_s1 && valid_q[idx_s1];
	assign match     = scan_live && (rd_s1.edge_id == edge_q);
	assign age       = now_q - rd_s1.seen;
	assign stale     = age > max_unobserved;
	assign sw_new    = scan_live && (op_q == OP_SWEEP) && (stale || rd_s1.published);
	assign sw_act    = stale ? ACT_REMOVED : ACT_BLOCK;
	assign sw_cnt    = stale ? '0 : rd_s1.count;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		slot_ok  = hit_q || free_any;
		slot_idx = hit_q ? hit_idx_q : free_idx;
		old_cnt  = hit_q ? hit_cnt_q : '0;
		old_pub  = hit_q && hit_pub_q;
		if (op_q == OP_FORCE) begin
			new_cnt = (publish_min == CNT_MAX) ? CNT_MAX : publish_min + 1'b1;
			new_pub = 1'b1;
			upd_act = ACT_BLOCK;
		end else begin
			new_cnt = (old_cnt == CNT_MAX) ? CNT_MAX : old_cnt + 1'b1;
			new_pub = old_pub || (new_cnt > publish_min);
			upd_act = (new_cnt > publish_min) ? ACT_BLOCK : ACT_NONE;
		end
		wr_en   = cmd.commit && slot_ok &&
			((op_q == OP_OBSERVE) || (op_q == OP_FORCE));
		wr_data = '{edge_id: edge_q, count: new_cnt, seen: now_q, published: new_pub};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			hit_q    <= 1'b0;
			held_v_q <= 1'b0;
		end else begin
			if (cmd.scan_start) begin
				hit_q    <= 1'b0;
				held_v_q <= 1'b0;
			end else begin
				if (match && !hit_q && (op_q != OP_SWEEP)) hit_q <= 1'b1;
				if (sw_new) held_v_q <= 1'b1;
			end
			if (scan_live && (op_q == OP_SWEEP) && stale) begin
				valid_q[idx_s1] <= 1'b0;
			end
			if (wr_en) begin
				valid_q[slot_idx] <= 1'b1;
			end
			if (cmd.commit && (op_q == OP_DELETE) && hit_q) begin
				valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (match && !hit_q) begin
			hit_idx_q <= idx_s1;
			hit_cnt_q <= rd_s1.count;
			hit_pub_q <= rd_s1.published;
		end
		if (sw_new) begin
			held_edge_q <= rd_s1.edge_id;
			held_act_q  <= sw_act;
			held_cnt_q  <= sw_cnt;
		end
	end

	always_comb begin
		emit    = 1'b0;
		em_edge = edge_q;
		em_act  = ACT_NONE;
		em_cnt  = '0;
		em_last = 1'b1;
		if (cmd.emit_filt) begin
			emit   = 1'b1;
			em_act = ACT_FILTERED;
		end else if (sw_new && held_v_q) begin
			emit    = 1'b1;
			em_edge = held_edge_q;
			em_act  = held_act_q;
			em_cnt  = held_cnt_q;
			em_last = 1'b0;
		end else if (cmd.commit) begin
			emit = 1'b1;
			case (op_q)
				OP_SWEEP: begin
					em_edge = held_v_q ? held_edge_q : '0;
					em_act  = held_v_q ? held_act_q : ACT_NONE;
					em_cnt  = held_v_q ? held_cnt_q : '0;
				end
				OP_DELETE: begin
					em_act = hit_q ? ACT_REMOVED : ACT_NONE;
				end
				default: begin
					em_act = slot_ok ? upd_act : ACT_FULL;
					em_cnt = slot_ok ? new_cnt : '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_edge_q <= em_edge;
			out_act_q  <= em_act;
			out_cnt_q  <= em_cnt;
			out_last_q <= em_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_edge  = out_edge_q;
	assign action    = out_act_q;
	assign obs_count = out_cnt_q;
	assign last      = out_last_q;

endmodule

[rtl/core/blockade_confirm_age_table.sv]
// ----------------------------------------------------------------------------
// blockade_confirm_age_table
// Table of tracked road edges with observation counts, publishing and aging.
//
// A request word is taken when start is high and busy is low. Each request
// yields one result word (a sweep yields one per reported entry, or one
// word if it reports none) on out_edge, action, obs_count and last, each
// shown for a single cycle while out_valid is high; last marks the final
// word of the request. The receiver cannot stall: every result word must
// be taken when shown. Every request that is not filtered walks the entry
// memory through its single read port, one entry per cycle, and busy stays
// high through the commit; a filtered request skips the walk. The final
// result word appears in the cycle in which busy falls; sweep words before
// it appear while busy is still high.
// Registers publish_min (address 0) and max_unobserved (address 4) sit on
// the APB port; the user is to write them only while the block is idle,
// which the block itself does not enforce. Reset empties the table at once
// and restores publish_min to 30 and max_unobserved to 60000.
// ----------------------------------------------------------------------------
module blockade_confirm_age_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      opcode,
	input  logic [bcat_pkg::EDGE_W-1:0]     edge_id,
	input  logic                            already_blocked,
	input  logic                            zone_edge,
	input  logic                            intersection_edge,
	input  logic [bcat_pkg::TIME_W-1:0]     now,
	output logic                            out_valid,
	output logic [bcat_pkg::EDGE_W-1:0]     out_edge,
	output logic [2:0]                      action,
	output logic [bcat_pkg::CNT_W-1:0]      obs_count,
	output logic                            last,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bcat_pkg::ADDR_W-1:0]     paddr,
	input  logic [bcat_pkg::DATA_W-1:0]     pwdata,
	output logic [bcat_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);
	import bcat_pkg::*;

	ctl_cmd_t          cmd;
	ctl_sts_t          sts;
	logic [CNT_W-1:0]  publish_min_q;
	logic [TIME_W-1:0] max_unobserved_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			publish_min_q    <= CNT_W'(30);
			max_unobserved_q <= TIME_W'(60000);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_PUBLISH_MIN:    publish_min_q    <= pwdata[CNT_W-1:0];
				REG_MAX_UNOBSERVED: max_unobserved_q <= pwdata[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PUBLISH_MIN:    prdata = DATA_W'(publish_min_q);
			REG_MAX_UNOBSERVED: prdata = DATA_W'(max_unobserved_q);
			default:            prdata = '0;
		endcase
	end

	bcat_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	bcat_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.opcode            (opcode),
		.edge_id           (edge_id),
		.already_blocked   (already_blocked),
		.zone_edge         (zone_edge),
		.intersection_edge (intersection_edge),
		.now               (now),
		.publish_min       (publish_min_q),
		.max_unobserved    (max_unobserved_q),
		.out_valid         (out_valid),
		.out_edge          (out_edge),
		.action            (action),
		.obs_count         (obs_count),
		.last              (last)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !busy)
		else $error("final result word shown while still busy");

	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !cmd.scan_step && !cmd.commit)
		else $error("table activity while idle");

	a_commit_emits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid && last)
		else $error("commit without final result word");

endmodule

[tb/sv/blockade_confirm_age_table_test.sv]
// ----------------------------------------------------------------------------
// blockade_confirm_age_table_test
// Self-checking test of the blockade confirmation and age table.
//
// Requests are driven through the start/busy handshake and every result word
// is compared with a table model kept here, which is updated at the clock edge
// that takes each request. Directed requests cover the filters, publishing,
// saturation, a full table and wrapped ages. Random traffic then runs under
// several register settings, the extremes among them, with random gaps.
// ----------------------------------------------------------------------------
module blockade_confirm_age_table_test;
	import bcat_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int POOL_SIZE      = 24;

	typedef struct packed {
		logic [EDGE_W-1:0] edge_id;
		logic [2:0]        act;
		logic [CNT_W-1:0]  cnt;
		logic              fin;
	} result_word_t;

	logic              clk               = 1'b0;
	logic              arst_n            = 1'b0;
	logic              start             = 1'b0;
	logic              busy;
	logic [1:0]        opcode            = OP_OBSERVE;
	logic [EDGE_W-1:0] edge_id           = '0;
	logic              already_blocked   = 1'b0;
	logic              zone_edge         = 1'b0;
	logic              intersection_edge = 1'b0;
	logic [TIME_W-1:0] now               = '0;
	logic              out_valid;
	logic [EDGE_W-1:0] out_edge;
	logic [2:0]        action;
	logic [CNT_W-1:0]  obs_count;
	logic              last;
	logic              psel              = 1'b0;
	logic              penable           = 1'b0;
	logic              pwrite            = 1'b0;
	logic [ADDR_W-1:0] paddr             = '0;
	logic [DATA_W-1:0] pwdata            = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	bit                tbl_valid [ENTRIES];
	bit [EDGE_W-1:0]   tbl_edge  [ENTRIES];
	bit [CNT_W-1:0]    tbl_count [ENTRIES];
	bit [TIME_W-1:0]   tbl_seen  [ENTRIES];
	bit                tbl_pub   [ENTRIES];
	logic [CNT_W-1:0]  cfg_publish_min    = 8'd30;
	logic [TIME_W-1:0] cfg_max_unobserved = 32'd60000;

	result_word_t pending_words[$];
	int unsigned  n_requests  = 0;
	int unsigned  n_words     = 0;
	int unsigned  n_errors    = 0;
	int unsigned  idle_cycles = 0;
	bit           burst_mode  = 1'b0;

	blockade_confirm_age_table i_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int find_slot(logic [EDGE_W-1:0] eid);
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && tbl_edge[i] == eid)
				return i;
		return -1;
	endfunction

	function automatic result_word_t make_word(logic [EDGE_W-1:0] eid, logic [2:0] act,
		logic [CNT_W-1:0] cnt);
		result_word_t w;
		w.edge_id = eid;
		w.act     = act;
		w.cnt     = cnt;
		w.fin     = 1'b0;
		return w;
	endfunction

	function automatic void predict_request(logic [1:0] op, logic [EDGE_W-1:0] eid,
		logic blk, logic zone, logic inter, logic [TIME_W-1:0] t);
		result_word_t words[$];
		result_word_t w;
		int slot;
		logic [TIME_W-1:0] age;
		slot = -1;
		case (op)
			OP_OBSERVE, OP_FORCE: begin
				if (blk || zone || (op == OP_OBSERVE && inter)) begin
					words = {words, make_word(eid, ACT_FILTERED, 8'd0)};
				end else begin
					slot = find_slot(eid);
					if (slot < 0) begin
						for (int i = 0; i < ENTRIES && slot < 0; i++)
							if (!tbl_valid[i])
								slot = i;
						if (slot >= 0) begin
							tbl_valid[slot] = 1'b1;
							tbl_edge[slot]  = eid;
							tbl_count[slot] = '0;
							tbl_pub[slot]   = 1'b0;
						end
					end
					if (slot < 0) begin
						words = {words, make_word(eid, ACT_FULL, 8'd0)};
					end else begin
						tbl_seen[slot] = t;
						if (op == OP_OBSERVE) begin
							if (tbl_count[slot] != CNT_MAX)
								tbl_count[slot]++;
							if (tbl_count[slot] > cfg_publish_min)
								tbl_pub[slot] = 1'b1;
							words = {words, make_word(eid,
								(tbl_count[slot] > cfg_publish_min) ? ACT_BLOCK : ACT_NONE,
								tbl_count[slot])};
						end else begin
							tbl_count[slot] = (cfg_publish_min != CNT_MAX) ?
								cfg_publish_min + 8'd1 : CNT_MAX;
							tbl_pub[slot] = 1'b1;
							words = {words, make_word(eid, ACT_BLOCK, tbl_count[slot])};
						end
					end
				end
			end
			OP_DELETE: begin
				slot = find_slot(eid);
				if (slot >= 0) begin
					tbl_valid[slot] = 1'b0;
					words = {words, make_word(eid, ACT_REMOVED, 8'd0)};
				end else begin
					words = {words, make_word(eid, ACT_NONE, 8'd0)};
				end
			end
			OP_SWEEP: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_valid[i]) begin
						age = t - tbl_seen[i];
						if (age > cfg_max_unobserved) begin
							tbl_valid[i] = 1'b0;
							words = {words, make_word(tbl_edge[i], ACT_REMOVED, 8'd0)};
						end else if (tbl_pub[i]) begin
							words = {words, make_word(tbl_edge[i], ACT_BLOCK, tbl_count[i])};
						end
					end
				end
				if (words.size() == 0)
					words = {words, make_word(16'd0, ACT_NONE, 8'd0)};
			end
		endcase
		foreach (words[k]) begin
			w     = words[k];
			w.fin = (k == words.size() - 1);
			pending_words = {pending_words, w};
		end
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", field, want, got);
			n_errors++;
		end
	endfunction

	// check the word shown, then model the request taken at this edge
	always @(posedge clk) begin : check_words
		result_word_t want;
		if (arst_n && out_valid === 1'b1) begin
			n_words++;
			if (pending_words.size() == 0) begin
				$error("unexpected result word: out_edge %0h action %0d obs_count %0d",
					out_edge, action, obs_count);
				n_errors++;
			end else begin
				want = pending_words.pop_front();
				check_field("out_edge", want.edge_id, out_edge);
				check_field("action", want.act, action);
				check_field("obs_count", want.cnt, obs_count);
				check_field("last", want.fin, last);
			end
		end
		if (arst_n && start && busy === 1'b0) begin
			n_requests++;
			predict_request(opcode, edge_id, already_blocked, zone_edge,
				intersection_edge, now);
		end
	end

	always @(posedge clk) begin
		if ((start && busy === 1'b0) || out_valid === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a word moving", idle_cycles);
			$display("TEST FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(input logic [1:0] op, input logic [EDGE_W-1:0] eid,
		input logic blk, input logic zone, input logic inter, input logic [TIME_W-1:0] t);
		int unsigned gap;
		if ($urandom_range(0, 7) == 0)
			burst_mode = !burst_mode;
		gap = burst_mode ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start             <= 1'b1;
		opcode            <= op;
		edge_id           <= eid;
		already_blocked   <= blk;
		zone_edge         <= zone;
		intersection_edge <= inter;
		now               <= t;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0 || busy !== 1'b0);
		repeat (4) @(posedge clk);
	endtask

	task automatic access_register(input logic wr, input logic idx,
		input logic [DATA_W-1:0] wdata);
		logic [DATA_W-1:0] held;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (!wr) begin
			held = (idx == REG_PUBLISH_MIN) ? DATA_W'(cfg_publish_min) : cfg_max_unobserved;
			check_field(idx == REG_PUBLISH_MIN ? "publish_min" : "max_unobserved",
				held, prdata);
		end
	endtask

	task automatic write_register(input logic idx, input logic [DATA_W-1:0] value);
		wait_quiet();
		access_register(1'b1, idx, value);
		if (idx == REG_PUBLISH_MIN)
			cfg_publish_min = value[CNT_W-1:0];
		else
			cfg_max_unobserved = value;
		access_register(1'b0, idx, '0);
	endtask

	task automatic test_register_defaults();
		access_register(1'b0, REG_PUBLISH_MIN, '0);
		access_register(1'b0, REG_MAX_UNOBSERVED, '0);
	endtask

	task automatic test_basic_requests();
		send_request(OP_OBSERVE, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd0);
		send_request(OP_OBSERVE, 16'hFFFF, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
		send_request(OP_OBSERVE, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd10);
		send_request(OP_OBSERVE, 16'h1111, 1'b1, 1'b0, 1'b0, 32'd10);
		send_request(OP_OBSERVE, 16'h2222, 1'b0, 1'b1, 1'b0, 32'd10);
		send_request(OP_OBSERVE, 16'h3333, 1'b0, 1'b0, 1'b1, 32'd10);
		send_request(OP_FORCE, 16'h4444, 1'b1, 1'b0, 1'b0, 32'd10);
		send_request(OP_FORCE, 16'h5555, 1'b0, 1'b1, 1'b0, 32'd10);
		send_request(OP_FORCE, 16'h6666, 1'b0, 1'b0, 1'b1, 32'd20);
		send_request(OP_SWEEP, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd30);
		send_request(OP_DELETE, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd30);
		send_request(OP_DELETE, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd30);
		send_request(OP_SWEEP, 16'hABCD, 1'b1, 1'b1, 1'b1, 32'd60031);
		send_request(OP_SWEEP, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd0);
		// seen after now: the modular age is huge
		send_request(OP_OBSERVE, 16'h7777, 1'b0, 1'b0, 1'b0, 32'd1000);
		send_request(OP_SWEEP, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd999);
	endtask

	task automatic test_table_full();
		for (int i = 0; i < ENTRIES; i++)
			send_request(OP_OBSERVE, EDGE_W'(16'h1000 + i * 16'h0111), 1'b0, 1'b0, 1'b0,
				32'd500);
		send_request(OP_OBSERVE, 16'hBEEF, 1'b0, 1'b0, 1'b0, 32'd500);
		send_request(OP_FORCE, 16'hBEEF, 1'b0, 1'b0, 1'b0, 32'd500);
		send_request(OP_DELETE, 16'h1555, 1'b0, 1'b0, 1'b0, 32'd500);
		send_request(OP_OBSERVE, 16'hBEEF, 1'b0, 1'b0, 1'b0, 32'd500);
		send_request(OP_SWEEP, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd60501);
	endtask

	task automatic test_count_extremes();
		write_register(REG_PUBLISH_MIN, 32'd254);
		send_request(OP_FORCE, 16'hA5A5, 1'b0, 1'b0, 1'b0, 32'd100);
		send_request(OP_OBSERVE, 16'hA5A5, 1'b0, 1'b0, 1'b0, 32'd100);
		write_register(REG_PUBLISH_MIN, 32'd0);
		send_request(OP_OBSERVE, 16'h5A5A, 1'b0, 1'b0, 1'b0, 32'd100);
		write_register(REG_MAX_UNOBSERVED, 32'd0);
		send_request(OP_SWEEP, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd100);
		send_request(OP_SWEEP, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd101);
		write_register(REG_MAX_UNOBSERVED, 32'hFFFF_FFFF);
		send_request(OP_OBSERVE, 16'h0F0F, 1'b0, 1'b0, 1'b0, 32'd200);
		send_request(OP_SWEEP, 16'h0000, 1'b0, 1'b0, 1'b0, 32'd199);
	endtask

	task automatic test_random_traffic();
		logic [EDGE_W-1:0] pool [POOL_SIZE];
		logic [TIME_W-1:0] clock_ms;
		logic [EDGE_W-1:0] eid;
		logic [TIME_W-1:0] t;
		logic [1:0]        op;
		int unsigned       step;
		int unsigned       pick;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_register(REG_PUBLISH_MIN, 32'd3);
					write_register(REG_MAX_UNOBSERVED, 32'd20000);
					step = 4000;
				end
				1: begin
					write_register(REG_PUBLISH_MIN, 32'd0);
					write_register(REG_MAX_UNOBSERVED, 32'd0);
					step = 2;
				end
				2: begin
					write_register(REG_PUBLISH_MIN, 32'd254);
					write_register(REG_MAX_UNOBSERVED, 32'hFFFF_FFFF);
					step = 32'hFFFF_FFFF;
				end
				3: begin
					write_register(REG_PUBLISH_MIN, 32'd1);
					write_register(REG_MAX_UNOBSERVED, 32'd5000);
					step = 1500;
				end
				default: begin
					write_register(REG_PUBLISH_MIN, $urandom_range(0, 7));
					write_register(REG_MAX_UNOBSERVED, $urandom_range(1000, 50000));
					step = 3000;
				end
			endcase
			clock_ms = (phase == 3) ? 32'hFFFF_F000 : $urandom();
			foreach (pool[i])
				pool[i] = EDGE_W'($urandom());
			repeat (32) begin
				pick = $urandom_range(0, 99);
				op = (pick < 50) ? OP_OBSERVE : (pick < 62) ? OP_FORCE :
					(pick < 77) ? OP_DELETE : OP_SWEEP;
				eid = ($urandom_range(0, 4) == 0) ? EDGE_W'($urandom()) :
					pool[$urandom_range(0, POOL_SIZE - 1)];
				clock_ms += $urandom_range(0, step);
				t = ($urandom_range(0, 19) == 0) ? $urandom() : clock_ms;
				send_request(op, eid, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
					$urandom_range(0, 7) == 0, t);
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_register_defaults();
		test_basic_requests();
		test_table_full();
		test_count_extremes();
		test_random_traffic();
		wait_quiet();
		repeat (40) @(posedge clk);
		if (pending_words.size() != 0) begin
			$error("%0d result words never arrived", pending_words.size());
			n_errors++;
		end
		$display("Ran %0d requests giving %0d result words: filters, publishing, saturation,",
			n_requests, n_words);
		$display("full table, wrapped ages and random traffic under several register settings.");
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

[sim.f]
rtl/core/bcat_pkg.sv
rtl/core/bcat_ctrl.sv
rtl/core/bcat_dp.sv
rtl/core/blockade_confirm_age_table.sv
tb/sv/blockade_confirm_age_table_test.sv
